/* rtl/mbd_pkg.sv */
`timescale 1ns / 1ps
package mbd_pkg;

  localparam int MAX_WIDTH_DEF   = 2048;
  localparam int HEIGHT_LIMIT    = 2048;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int ROW_W           = 11;
  localparam int SIZE_W          = 12;
  localparam int CHAN_CNT_W      = 3;
  localparam int NUM_CHAN        = 4;

  localparam logic [1:0] REG_SRC_WIDTH     = 2'd0;
  localparam logic [1:0] REG_SRC_HEIGHT    = 2'd1;
  localparam logic [1:0] REG_CHANNEL_COUNT = 2'd2;

  localparam logic [1:0] KIND_HOLD    = 2'd0;
  localparam logic [1:0] KIND_LINE_WR = 2'd1;
  localparam logic [1:0] KIND_EMIT2   = 2'd2;
  localparam logic [1:0] KIND_EMIT1   = 2'd3;

  typedef logic [NUM_CHAN-1:0][7:0] pixel_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       done;
    pixel_t     px;
  } mbd_entry_t;

endpackage

/* rtl/mbd_front.sv */
`timescale 1ns / 1ps
module mbd_front #(
  parameter int MAX_WIDTH = mbd_pkg::MAX_WIDTH_DEF,
  parameter int ADDR_W    = 10
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [31:0]                s_tdata,   // chan0, chan1, chan2, chan3
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [1:0]                 cfg_index,
  input  logic [mbd_pkg::SIZE_W-1:0] cfg_data,
  input  logic                       q_full,
  output logic                       q_push,
  output mbd_pkg::mbd_entry_t        q_entry,
  output logic [ADDR_W-1:0]          q_idx
);
  import mbd_pkg::*;

  localparam int COL_W = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int WB_W  = $clog2(MAX_WIDTH + 1);
  localparam int CW    = (WB_W > SIZE_W) ? WB_W : SIZE_W;

  logic [SIZE_W-1:0]     src_width;
  logic [SIZE_W-1:0]     src_height;
  logic [CHAN_CNT_W-1:0] channel_count;
  logic [COL_W-1:0]      col;
  logic [ROW_W-1:0]      row;

  logic [CW-1:0]     sw, w, col_ext, col_p1, w_last, pos, len, len_last;
  logic [SIZE_W-1:0] h, row_ext, row_p1, h_last;
  logic [2:0]        c;
  logic              w1, h1, accept, cfg_wr;
  pixel_t            px;

  assign cfg_ready = 1'b1;
  assign s_tready  = !q_full;
  assign accept    = s_tvalid && s_tready;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_comb begin
    sw = CW'(src_width);
    if (sw == '0) begin
      w = CW'(1);
    end else if (sw > CW'(MAX_WIDTH)) begin
      w = CW'(MAX_WIDTH);
    end else begin
      w = sw;
    end
    if (src_height == '0) begin
      h = SIZE_W'(1);
    end else if (src_height > SIZE_W'(HEIGHT_LIMIT)) begin
      h = SIZE_W'(HEIGHT_LIMIT);
    end else begin
      h = src_height;
    end
    if (channel_count == '0) begin
      c = 3'd1;
    end else if (channel_count > 3'd4) begin
      c = 3'd4;
    end else begin
      c = channel_count;
    end
    for (int i = 0; i < NUM_CHAN; i++) begin
      px[i] = (3'(i) < c) ? s_tdata[8*i +: 8] : 8'd0;
    end
  end

  always_comb begin
    w1       = (w == CW'(1));
    h1       = (h == SIZE_W'(1));
    col_ext  = CW'(col);
    row_ext  = SIZE_W'(row);
    col_p1   = col_ext + CW'(1);
    row_p1   = row_ext + SIZE_W'(1);
    w_last   = (w & ~CW'(1)) - CW'(1);
    h_last   = (h & ~SIZE_W'(1)) - SIZE_W'(1);
    pos      = w1 ? CW'(row) : col_ext;
    len      = w1 ? CW'(h) : w;
    len_last = (len & ~CW'(1)) - CW'(1);

    q_entry.px   = px;
    q_entry.kind = KIND_HOLD;
    q_entry.done = 1'b0;
    q_idx        = ADDR_W'(col >> 1);
    q_push       = 1'b0;
    if (!w1 && !h1) begin
      q_push = accept;
      if (col[0]) begin
        if (row[0]) begin
          q_entry.kind = KIND_EMIT2;
          q_entry.done = (row_ext == h_last) && (col_ext == w_last);
        end else begin
          q_entry.kind = KIND_LINE_WR;
        end
      end
    end else if (!(w1 && h1)) begin
      q_push = accept;
      if (pos[0]) begin
        q_entry.kind = KIND_EMIT1;
        q_entry.done = (pos == len_last);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width     <= SIZE_W'(2);
      src_height    <= SIZE_W'(2);
      channel_count <= CHAN_CNT_W'(4);
      col           <= '0;
      row           <= '0;
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_SRC_WIDTH: begin
          src_width <= cfg_data;
          col <= '0;
          row <= '0;
        end
        REG_SRC_HEIGHT: begin
          src_height <= cfg_data;
          col <= '0;
          row <= '0;
        end
        REG_CHANNEL_COUNT: begin
          channel_count <= cfg_data[CHAN_CNT_W-1:0];
          col <= '0;
          row <= '0;
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      if (col_p1 >= w) begin
        col <= '0;
        if (row_p1 >= h) begin
          row <= '0;
        end else begin
          row <= row_p1[ROW_W-1:0];
        end
      end else begin
        col <= col_p1[COL_W-1:0];
      end
    end
  end

endmodule

/* rtl/mbd_queue.sv */
`timescale 1ns / 1ps
module mbd_queue #(
  parameter int DEPTH  = mbd_pkg::QUEUE_DEPTH_DEF,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic              valid,
  output logic [DATA_W-1:0] pop_data
);
  import mbd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push, do_pop;

  assign full     = (count == CNT_W'(DEPTH));
  assign valid    = (count != '0);
  assign pop_data = slots[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/mbd_back.sv */
`timescale 1ns / 1ps
module mbd_back #(
  parameter int MAX_WIDTH = mbd_pkg::MAX_WIDTH_DEF,
  parameter int ADDR_W    = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  mbd_pkg::mbd_entry_t q_entry,
  input  logic [ADDR_W-1:0]   q_idx,
  output logic                q_pop,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [31:0]         m_tdata,   // out0, out1, out2, out3
  output logic                m_tlast    // level_done
);
  import mbd_pkg::*;

  localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;

  logic [NUM_CHAN*9-1:0] line_mem [LINE_DEPTH];
  logic [NUM_CHAN*9-1:0] line_rd, line_wr;

  pixel_t     held;
  logic       b_valid, b_valid_next, b_done;
  logic [1:0] b_kind;
  pixel_t     b_held, b_px;
  logic       out_free, a_go, a_emit;
  pixel_t     res;

  assign out_free = !m_tvalid || m_tready;
  assign a_go     = q_valid && (!b_valid || out_free);
  assign a_emit   = (q_entry.kind == KIND_EMIT2) || (q_entry.kind == KIND_EMIT1);
  assign q_pop    = a_go;
  assign b_valid_next = (a_go && a_emit) || (b_valid && !out_free);

  always_comb begin
    for (int i = 0; i < NUM_CHAN; i++) begin
      line_wr[9*i +: 9] = {1'b0, held[i]} + {1'b0, q_entry.px[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (a_go && (q_entry.kind == KIND_LINE_WR)) begin
      line_mem[q_idx] <= line_wr;
    end
  end

  always_ff @(posedge clk) begin
    if (a_go && a_emit) begin
      line_rd <= line_mem[q_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (a_go && (q_entry.kind == KIND_HOLD)) begin
      held <= q_entry.px;
    end
  end

  always_ff @(posedge clk) begin
    if (a_go && a_emit) begin
      b_kind <= q_entry.kind;
      b_done <= q_entry.done;
      b_held <= held;
      b_px   <= q_entry.px;
    end
  end

  always_comb begin
    logic [9:0] s2;
    logic [8:0] s1;
    for (int i = 0; i < NUM_CHAN; i++) begin
      s2 = {1'b0, line_rd[9*i +: 9]} + {2'b0, b_held[i]} + {2'b0, b_px[i]};
      s1 = {1'b0, b_held[i]} + {1'b0, b_px[i]};
      res[i] = (b_kind == KIND_EMIT2) ? s2[9:2] : s1[8:1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      b_valid <= b_valid_next;
      if (out_free) begin
        m_tvalid <= b_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && b_valid) begin
      m_tdata <= res;
      m_tlast <= b_done;
    end
  end

endmodule

/* rtl/mipmap_box_downsample.sv */
`timescale 1ns / 1ps
// 2x2 box-filter mipmap reduction, one source level per pass.
// Input stream: s_tvalid/s_tready/s_tdata carry one source pixel per beat in
// raster order, channel 0 in the low byte. Output stream: m_tdata carries
// the averaged pixel, m_tlast marks the last pixel of the destination level.
// Config channel: cfg_valid/cfg_ready/cfg_index/cfg_data writes src_width (0),
// src_height (1), channel_count (2); any write to one of these restarts the
// level. Write only while the block is idle. cfg_ready is always high.
// Throughput: one pixel per cycle sustained while the queue is not full. Only
// odd-column pixels of odd rows (or odd pixels of a single line) produce a beat.
// Each result passes through the queue write, then the line-store read and
// held-pixel stage, then the output register.
// The line store holds (MAX_WIDTH+1)/2 pair sums; each queue entry makes at
// most one write or one registered read; it needs no clearing after reset.
// Reset: rst (synchronous) empties the queue and pipeline, zeroes positions
// and loads width 2, height 2, four channels.
// Stall: m_tready low holds the output; a QUEUE_DEPTH-deep queue (default 4)
// plus one stage absorb pixels, then s_tready drops until the receiver drains.
module mipmap_box_downsample #(
  parameter int MAX_WIDTH   = mbd_pkg::MAX_WIDTH_DEF,
  parameter int QUEUE_DEPTH = mbd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [31:0]                s_tdata,   // chan0, chan1, chan2, chan3
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [31:0]                m_tdata,   // out0, out1, out2, out3
  output logic                       m_tlast,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [1:0]                 cfg_index,
  input  logic [mbd_pkg::SIZE_W-1:0] cfg_data
);
  import mbd_pkg::*;

  localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int Q_W        = ADDR_W + $bits(mbd_entry_t);

  logic               q_push, q_full, q_pop, q_valid;
  mbd_entry_t         f_entry, b_entry;
  logic [ADDR_W-1:0]  f_idx, b_idx;
  logic [Q_W-1:0]     q_out;

  mbd_front #(.MAX_WIDTH(MAX_WIDTH), .ADDR_W(ADDR_W)) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (f_entry),
    .q_idx     (f_idx)
  );

  mbd_queue #(.DEPTH(QUEUE_DEPTH), .DATA_W(Q_W)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data ({f_idx, f_entry}),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_out)
  );

  assign b_idx   = q_out[Q_W-1 -: ADDR_W];
  assign b_entry = q_out[$bits(mbd_entry_t)-1:0];

  mbd_back #(.MAX_WIDTH(MAX_WIDTH), .ADDR_W(ADDR_W)) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_entry  (b_entry),
    .q_idx    (b_idx),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("queue push while full");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue pop while empty");

  a_out_idle_after_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

endmodule

/* tb/sv/tb_mipmap_box_downsample.sv */
`timescale 1ns / 1ps
module tb_mipmap_box_downsample;
  import mbd_pkg::*;

  localparam int MAX_W = MAX_WIDTH_DEF;
  localparam int LINE_DEPTH = MAX_W / 2;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int SETTLE = 8;
  localparam int RANDOM_PIXELS = 530;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  localparam int STALL_NONE = 0;
  localparam int STALL_COIN = 1;
  localparam int STALL_HEAVY = 2;
  localparam int STALL_THIRD = 3;

  typedef struct packed {
    pixel_t ch;
    logic   last;
  } avg_pixel_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [31:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic m_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [SIZE_W-1:0] cfg_data = '0;

  mipmap_box_downsample DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pixel_t src_pixels[$];
  avg_pixel_t avg_q[$];
  int errors = 0;
  int cycles = 0;

  // mirror of the block state
  logic [SIZE_W-1:0] width_reg;
  logic [SIZE_W-1:0] height_reg;
  logic [CHAN_CNT_W-1:0] chans_reg;
  pixel_t held_px;
  logic [35:0] pair_line [0:LINE_DEPTH-1];
  int unsigned col_pos;
  int unsigned row_pos;

  task automatic downsample_step(input pixel_t pix);
    int unsigned w, h, c, idx, pos, len, s;
    pixel_t px, res;
    logic [35:0] e;
    logic emit, done;
    w = (width_reg == 0) ? 1 : ((width_reg > MAX_W) ? MAX_W : width_reg);
    h = (height_reg == 0) ? 1 : ((height_reg > HEIGHT_LIMIT) ? HEIGHT_LIMIT : height_reg);
    c = (chans_reg == 0) ? 1 : ((chans_reg > NUM_CHAN) ? NUM_CHAN : chans_reg);
    res = '0;
    emit = 1'b0;
    done = 1'b0;
    for (int i = 0; i < NUM_CHAN; i++) px[i] = (i < c) ? pix[i] : 8'd0;
    if (w > 1 && h > 1) begin
      idx = col_pos >> 1;
      if (col_pos % 2 == 0) begin
        held_px = px;
      end else if (row_pos % 2 == 0) begin
        for (int i = 0; i < NUM_CHAN; i++) e[9*i +: 9] = 9'(held_px[i]) + 9'(px[i]);
        pair_line[idx] = e;
      end else begin
        e = pair_line[idx];
        for (int i = 0; i < NUM_CHAN; i++) begin
          s = e[9*i +: 9] + held_px[i] + px[i];
          res[i] = (i < c) ? 8'(s >> 2) : 8'd0;
        end
        emit = 1'b1;
        done = (row_pos == (h & ~32'd1) - 1) && (col_pos == (w & ~32'd1) - 1);
      end
    end else if (!(w == 1 && h == 1)) begin
      pos = (w == 1) ? row_pos : col_pos;
      len = (w == 1) ? h : w;
      if (pos % 2 == 0) begin
        held_px = px;
      end else begin
        for (int i = 0; i < NUM_CHAN; i++) begin
          s = held_px[i] + px[i];
          res[i] = (i < c) ? 8'(s >> 1) : 8'd0;
        end
        emit = 1'b1;
        done = (pos == (len & ~32'd1) - 1);
      end
    end
    if (emit) avg_q.push_back('{ch: res, last: done});
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  // cycle limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // source driver: bursts with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else if (!s_tvalid || s_tready) begin
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (src_pixels.size() > 0) begin
        s_tvalid <= 1'b1;
        s_tdata <= src_pixels.pop_front();
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // sink stall pattern
  int stall_mode = STALL_NONE;
  int stall_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(STALL_NONE, STALL_THIRD);
        stall_left = $urandom_range(16, 128);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        STALL_NONE: m_tready <= 1'b1;
        STALL_COIN: m_tready <= 1'($urandom_range(0, 1));
        STALL_HEAVY: m_tready <= ($urandom_range(0, 7) == 0);
        default: m_tready <= (cycles % 3 == 0);
      endcase
    end
  end

  // monitor: check output beats, track config and input beats
  always @(posedge clk) begin
    avg_pixel_t want;
    if (rst) begin
      width_reg = 12'd2;
      height_reg = 12'd2;
      chans_reg = 3'd4;
      held_px = '0;
      col_pos = 0;
      row_pos = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (avg_q.size() == 0) begin
          $error("unexpected output beat: data %h last %b", m_tdata, m_tlast);
          errors++;
        end else begin
          want = avg_q.pop_front();
          for (int i = 0; i < NUM_CHAN; i++) begin
            if (m_tdata[8*i +: 8] !== want.ch[i]) begin
              $error("out%0d: expected %0d, got %0d", i, want.ch[i], m_tdata[8*i +: 8]);
              errors++;
            end
          end
          if (m_tlast !== want.last) begin
            $error("level_done: expected %0b, got %0b", want.last, m_tlast);
            errors++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SRC_WIDTH: width_reg = cfg_data;
          REG_SRC_HEIGHT: height_reg = cfg_data;
          REG_CHANNEL_COUNT: chans_reg = cfg_data[CHAN_CNT_W-1:0];
          default: ;
        endcase
        if (cfg_index != REG_UNUSED) begin
          col_pos = 0;
          row_pos = 0;
        end
      end
      if (s_tvalid && s_tready) downsample_step(s_tdata);
    end
  end

  task automatic cfg_write(input logic [1:0] idx, input logic [SIZE_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_level(input int w, input int h, input logic [SIZE_W-1:0] c);
    cfg_write(REG_SRC_WIDTH, SIZE_W'(w));
    cfg_write(REG_SRC_HEIGHT, SIZE_W'(h));
    cfg_write(REG_CHANNEL_COUNT, c);
  endtask

  function automatic pixel_t rand_pixel();
    pixel_t p;
    for (int i = 0; i < NUM_CHAN; i++) begin
      case ($urandom_range(0, 7))
        0: p[i] = 8'h00;
        1: p[i] = 8'hff;
        default: p[i] = 8'($urandom());
      endcase
    end
    return p;
  endfunction

  task automatic queue_pixels(input int n);
    @(negedge clk);
    repeat (n) src_pixels.push_back(rand_pixel());
  endtask

  // drained: nothing queued, nothing on the bus, no result outstanding
  task automatic wait_idle();
    do @(negedge clk); while (src_pixels.size() != 0 || s_tvalid || avg_q.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  function automatic int pick_size(input int hi);
    if ($urandom_range(0, 1)) return 1 << $urandom_range(0, $clog2(hi));
    return $urandom_range(0, hi);
  endfunction

  initial begin
    int w, h, lvl, n, sent;
    logic [SIZE_W-1:0] cdat;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    // reset config: 2x2, four channels; saturation, zero, truncation, bit patterns
    src_pixels = '{'1, '1, '1, '1,
                   '0, '0, '0, '0,
                   '1, '1, '1, 32'hfefefefe,
                   32'h03030303, '0, '0, '0,
                   32'haa55aa55, 32'h55aa55aa, 32'h0f0f0f0f, 32'hf0f0f0f0};
    wait_idle();

    set_level(4, 4, 12'd4);     queue_pixels(48);   wait_idle();
    set_level(8, 4, 12'd3);     queue_pixels(64);   wait_idle();
    set_level(1, 16, 12'd2);    queue_pixels(48);   wait_idle();
    set_level(16, 1, 12'd1);    queue_pixels(48);   wait_idle();
    set_level(1, 1, 12'd4);     queue_pixels(10);   wait_idle();
    set_level(0, 0, 12'd0);     queue_pixels(5);    wait_idle();
    set_level(3, 5, 12'd4);     queue_pixels(45);   wait_idle();
    set_level(5, 1, 12'd4);     queue_pixels(20);   wait_idle();
    set_level(1, 7, 12'hffd);   queue_pixels(14);   wait_idle();
    set_level(4095, 1, 12'd7);  queue_pixels(150);  wait_idle();
    set_level(1, 2048, 12'd4);  queue_pixels(150);  wait_idle();
    set_level(2, 4095, 12'd5);  queue_pixels(150);  wait_idle();

    sent = 0;
    while (sent < RANDOM_PIXELS) begin
      w = pick_size(32);
      h = pick_size(8);
      cdat = {9'($urandom()), 3'($urandom_range(0, 7))};
      set_level(w, h, cdat);
      if ($urandom_range(0, 5) == 0) cfg_write(REG_UNUSED, SIZE_W'($urandom()));
      lvl = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, lvl) : lvl * $urandom_range(1, 2);
      if (n > 300) n = 300;
      if (n > RANDOM_PIXELS - sent) n = RANDOM_PIXELS - sent;
      queue_pixels(n);
      sent += n;
      wait_idle();
    end

    repeat (20) @(negedge clk);
    if (avg_q.size() != 0) errors++;
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/mbd_pkg.sv
rtl/mbd_front.sv
rtl/mbd_queue.sv
rtl/mbd_back.sv
rtl/mipmap_box_downsample.sv
tb/sv/tb_mipmap_box_downsample.sv
